/* design/wfpd_pkg.sv */
// Package: item types, register indexes, reset values and constants for the wall-follow drive.
`default_nettype none
package wfpd_pkg;

  // Input item
  typedef struct packed {
    logic        func;
    logic [12:0] right_dist;
    logic        guard_enable;
    logic [31:0] now_ms;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [11:0] left_speed;
    logic [11:0] right_speed;
  } out_item_t;

  // Configuration port widths
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_TARGET    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEAD_BAND = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WALL_MAX  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BASE      = 3'd6;

  // Register reset values
  localparam logic [9:0]  RST_TARGET    = 10'd152;
  localparam logic [7:0]  RST_DEAD_BAND = 8'd24;
  localparam logic [12:0] RST_WALL_MAX  = 13'd200;
  localparam logic [11:0] RST_GAIN_P    = 12'd435;
  localparam logic [11:0] RST_GAIN_I    = 12'd0;
  localparam logic [11:0] RST_GAIN_D    = 12'd768;
  localparam logic [10:0] RST_BASE      = 11'd800;

  // Controller constants
  localparam logic [31:0] DT_MAX      = 32'd500;
  localparam logic [8:0]  DT_MIN      = 9'd1;
  localparam logic [10:0] GUARD_LEAN  = 11'd32;
  localparam logic [12:0] WHEEL_MIN   = 13'd160;
  localparam logic signed [23:0] INTEG_LIM  = 24'sd480000;
  localparam logic signed [23:0] INTEG_NLIM = -24'sd480000;

  // Multiplier constant operands
  localparam logic [19:0] K_MS_PER_S   = 20'd1000;
  localparam logic [19:0] K_US_PER_S   = 20'd1000000;
  localparam logic [19:0] K_HALF_DEN   = 20'd128000;

  // Divider geometry
  localparam int DivNumW = 48;
  localparam int DivDenW = 27;
  localparam int DivQW   = 10;

endpackage
`default_nettype wire

/* design/wfpd_div.sv */
// Restoring divider: one quotient bit per cycle, saturating quotient.
`default_nettype none
module wfpd_div
  import wfpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DivNumW-1:0] num,
  input  wire logic [DivDenW-1:0] den,
  output logic                    done,
  output logic [DivQW-1:0]        quot
);

  localparam int DvW  = DivDenW + DivQW;
  localparam int CntW = $clog2(DivQW + 1);
  localparam logic [CntW-1:0] CntTop = CntW'(DivQW);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivNumW-1:0] rem_r, rem_nxt;
  logic [DvW-1:0]     dv_r, dv_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [DivQW-1:0]   q_r, q_nxt;
  logic               ge;

  assign ge = rem_r >= DivNumW'(dv_r);

  // First step checks for overflow, then one quotient bit per step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = num;
      dv_nxt   = {den, {DivQW{1'b0}}};
      cnt_nxt  = CntTop;
      q_nxt    = '0;
    end else if (busy_r) begin
      dv_nxt  = dv_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntTop) begin
        if (ge) begin
          q_nxt    = '1;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        q_nxt = {q_r[DivQW-2:0], ge};
        if (ge) begin
          rem_nxt = rem_r - DivNumW'(dv_r);
        end
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

/* design/wall_follow_pid_drive.sv */
// Top level: wall-follow PID drive with one shared multiplier and an iterative divider.
//
//  channel | ports                          | direction
//  input   | in_valid, in_stall, in_data    | item in, stall out
//  result  | out_valid, out_stall, out_data | item out, stall in
//  config  | cfg_we, cfg_index, cfg_wdata   | write only
//
// A control item runs through decode, nine passes through the shared
// multiplier, eleven divider steps and the wheel clamp. Reset and guard items
// branch off at ST_PRE, dead-band items at ST_DEC. in_stall is high while an item is
// in work. The result register holds a finished item while out_stall is high;
// the next item is taken meanwhile. rst_n is synchronous and clears the state.
`default_nettype none
module wall_follow_pid_drive
  import wfpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  // Sequencer codes
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PRE  = 5'd1;
  localparam logic [4:0] ST_DEC  = 5'd2;
  localparam logic [4:0] ST_M0   = 5'd3;
  localparam logic [4:0] ST_M1   = 5'd4;
  localparam logic [4:0] ST_M2   = 5'd5;
  localparam logic [4:0] ST_M3   = 5'd6;
  localparam logic [4:0] ST_M4   = 5'd7;
  localparam logic [4:0] ST_M5   = 5'd8;
  localparam logic [4:0] ST_M6   = 5'd9;
  localparam logic [4:0] ST_M7   = 5'd10;
  localparam logic [4:0] ST_M8   = 5'd11;
  localparam logic [4:0] ST_ABS  = 5'd12;
  localparam logic [4:0] ST_DIV  = 5'd13;
  localparam logic [4:0] ST_FIN  = 5'd14;
  localparam logic [4:0] ST_PUT  = 5'd15;

  // Configuration registers
  logic [9:0]  target_r;
  logic [7:0]  dead_band_r;
  logic [12:0] wall_max_r;
  logic [11:0] gain_p_r, gain_i_r, gain_d_r;
  logic [10:0] base_r;

  // Controller state
  logic signed [19:0] integ_r, integ_nxt;
  logic signed [13:0] prev_err_r, prev_err_nxt;
  logic [31:0]        prev_time_r, prev_time_nxt;

  // Sequencer and datapath
  logic [4:0]         state_r, state_nxt;
  in_item_t           item_r;
  logic [8:0]         dt_r, dt_nxt;
  logic signed [13:0] err_r, err_nxt;
  logic signed [14:0] delta_r, delta_nxt;
  logic [18:0]        dtk_r, dtk_nxt;
  logic signed [47:0] prod_r;
  logic signed [47:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  // Shared multiplier
  logic signed [31:0] mul_a;
  logic [19:0]        mul_b;
  logic signed [52:0] mul_p;

  // Step decode helpers
  logic [31:0]        diff;
  logic               guard_hit;
  logic [13:0]        mag;
  logic signed [23:0] isum;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic               div_done;
  logic [DivQW-1:0]   div_q;
  logic [9:0]         half;
  logic [9:0]         qc;
  logic signed [12:0] corr;
  logic [11:0]        top;

  // Clamp one wheel to the low bound first, then to the high bound
  function automatic logic [11:0] wheel_clamp(input logic signed [12:0] v,
                                              input logic [11:0] hi);
    logic [11:0] r;
    if (v < $signed(WHEEL_MIN)) begin
      r = WHEEL_MIN[11:0];
    end else if (v > $signed({1'b0, hi})) begin
      r = hi;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= RST_TARGET;
      dead_band_r <= RST_DEAD_BAND;
      wall_max_r  <= RST_WALL_MAX;
      gain_p_r    <= RST_GAIN_P;
      gain_i_r    <= RST_GAIN_I;
      gain_d_r    <= RST_GAIN_D;
      base_r      <= RST_BASE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET:    target_r    <= cfg_wdata[9:0];
        REG_DEAD_BAND: dead_band_r <= cfg_wdata[7:0];
        REG_WALL_MAX:  wall_max_r  <= cfg_wdata[12:0];
        REG_GAIN_P:    gain_p_r    <= cfg_wdata[11:0];
        REG_GAIN_I:    gain_i_r    <= cfg_wdata[11:0];
        REG_GAIN_D:    gain_d_r    <= cfg_wdata[11:0];
        REG_BASE:      base_r      <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_M0: begin mul_a = 32'(dt_r);            mul_b = K_MS_PER_S;      end
      ST_M1: begin mul_a = 32'(err_r);           mul_b = 20'(dt_r);       end
      ST_M2: begin mul_a = 32'(err_r);           mul_b = 20'(gain_p_r);   end
      ST_M3: begin mul_a = prod_r[31:0];         mul_b = 20'(dtk_r);      end
      ST_M4: begin mul_a = 32'(integ_r);         mul_b = 20'(gain_i_r);   end
      ST_M5: begin mul_a = prod_r[31:0];         mul_b = 20'(dt_r);       end
      ST_M6: begin mul_a = 32'(delta_r);         mul_b = 20'(gain_d_r);   end
      ST_M7: begin mul_a = prod_r[31:0];         mul_b = K_US_PER_S;      end
      ST_M8: begin mul_a = 32'(dt_r);            mul_b = K_HALF_DEN;      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    prod_r <= mul_p[47:0];
  end

  // Step decode terms
  assign diff      = item_r.now_ms - prev_time_r;
  assign guard_hit = item_r.guard_enable && (item_r.right_dist > wall_max_r);
  assign mag       = err_r[13] ? 14'(-err_r) : 14'(err_r);
  assign isum      = 24'(integ_r) + $signed(prod_r[23:0]);

  // Rounding divide: |num| plus half the divisor over the divisor
  assign div_num = acc_r[47] ? DivNumW'(-acc_r) + DivNumW'(prod_r)
                             : DivNumW'(acc_r) + DivNumW'(prod_r);
  assign div_den = {prod_r[DivDenW-2:0], 1'b0};

  wfpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_ABS),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Correction and wheel bounds
  assign half = base_r[10:1];
  assign qc   = (div_q > half) ? half : div_q;
  assign corr = neg_r ? -$signed({3'b0, qc}) : $signed({3'b0, qc});
  assign top  = {1'b0, base_r} + {2'b0, half};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    integ_nxt     = integ_r;
    prev_err_nxt  = prev_err_r;
    prev_time_nxt = prev_time_r;
    dt_nxt        = dt_r;
    err_nxt       = err_r;
    delta_nxt     = delta_r;
    dtk_nxt       = dtk_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        err_nxt = $signed({1'b0, item_r.right_dist}) - $signed({4'b0, target_r});
        delta_nxt = 15'(err_nxt) - 15'(prev_err_r);
        if (diff == '0) begin
          dt_nxt = DT_MIN;
        end else if (diff > DT_MAX) begin
          dt_nxt = DT_MAX[8:0];
        end else begin
          dt_nxt = diff[8:0];
        end
        if (item_r.func || guard_hit) begin
          integ_nxt     = '0;
          prev_err_nxt  = '0;
          prev_time_nxt = item_r.now_ms;
        end
        if (item_r.func) begin
          state_nxt = ST_IDLE;
        end else if (guard_hit) begin
          res_nxt.left_speed  = (base_r < GUARD_LEAN) ? '0 : 12'(base_r - GUARD_LEAN);
          res_nxt.right_speed = {1'b0, base_r} + {1'b0, GUARD_LEAN};
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        prev_time_nxt = item_r.now_ms;
        if (mag < {6'b0, dead_band_r}) begin
          integ_nxt           = '0;
          prev_err_nxt        = err_r;
          res_nxt.left_speed  = {1'b0, base_r};
          res_nxt.right_speed = {1'b0, base_r};
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_M0;
        end
      end
      ST_M0: state_nxt = ST_M1;
      ST_M1: begin
        dtk_nxt   = prod_r[18:0];
        state_nxt = ST_M2;
      end
      ST_M2: begin
        // Integral update with clamp
        if (isum < INTEG_NLIM) begin
          integ_nxt = INTEG_NLIM[19:0];
        end else if (isum > INTEG_LIM) begin
          integ_nxt = INTEG_LIM[19:0];
        end else begin
          integ_nxt = isum[19:0];
        end
        prev_err_nxt = err_r;
        state_nxt    = ST_M3;
      end
      ST_M3: state_nxt = ST_M4;
      ST_M4: begin
        acc_nxt   = prod_r;
        state_nxt = ST_M5;
      end
      ST_M5: state_nxt = ST_M6;
      ST_M6: begin
        acc_nxt   = acc_r + prod_r;
        state_nxt = ST_M7;
      end
      ST_M7: state_nxt = ST_M8;
      ST_M8: begin
        acc_nxt   = acc_r + prod_r;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        neg_nxt   = acc_r[47];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        res_nxt.left_speed  = wheel_clamp(13'({2'b0, base_r}) + corr, top);
        res_nxt.right_speed = wheel_clamp(13'({2'b0, base_r}) - corr, top);
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register: load from the sequencer, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_PUT && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integ_r     <= '0;
      prev_err_r  <= '0;
      prev_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      prev_err_r  <= prev_err_nxt;
      prev_time_r <= prev_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == ST_PUT && (!out_valid_r || !out_stall)) begin
      out_data_r <= res_r;
    end
    dt_r    <= dt_nxt;
    err_r   <= err_nxt;
    delta_r <= delta_nxt;
    dtk_r   <= dtk_nxt;
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* test/wall_follow_pid_drive_tb.sv */
// Testbench for wall_follow_pid_drive: directed table, then random phases checked by a PID predictor.
`default_nettype none
module wall_follow_pid_drive_tb;
  import wfpd_pkg::*;

  // Item operations and the spare register slot
  localparam logic FUNC_STEP  = 1'b0;
  localparam logic FUNC_RESET = 1'b1;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

  // Controller constants in predictor terms
  localparam longint DT_FLOOR    = 1;
  localparam longint DT_CEIL     = 500;
  localparam longint LEAN        = 32;
  localparam longint WHEEL_FLOOR = 160;
  localparam longint INTEG_CAP   = 480000;
  localparam longint Q_SCALE     = 256000;
  localparam int     DIST_TOP    = 6400;

  // Run shape
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 110;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    bit        has_res;
    out_item_t res;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  // Register copies
  bit [9:0]  rg_target;
  bit [7:0]  rg_dead;
  bit [12:0] rg_wall;
  bit [11:0] rg_gp;
  bit [11:0] rg_gi;
  bit [11:0] rg_gd;
  bit [10:0] rg_base;

  // Controller state copies
  longint    pid_integral;
  longint    pid_last_err;
  bit [31:0] pid_last_ms;

  out_item_t speeds_due[$];
  stim_row_t plan[$];
  out_item_t due_now;
  bit [31:0] stamp_ms;
  int        errors = 0;
  int        cycles = 0;
  int        hold_seq = 0;
  int        hold_done = 0;
  bit        calm = 1'b0;

  wall_follow_pid_drive i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Advance the controller copy by one item; return 1 when a speed pair comes out
  function automatic bit predict_speeds(input in_item_t it, output out_item_t res);
    longint    base, half, meas, tgt, dead, err, mag, dt, delta;
    longint    num, den, quo, corr, wl, wr;
    bit [31:0] span;
    res = '0;
    base = rg_base;
    half = base / 2;
    if (it.func == FUNC_RESET) begin
      pid_integral = 0;
      pid_last_err = 0;
      pid_last_ms = it.now_ms;
      return 1'b0;
    end
    // Far wall with guard on: drop state, lean gently right
    if (it.guard_enable && it.right_dist > rg_wall) begin
      pid_integral = 0;
      pid_last_err = 0;
      pid_last_ms = it.now_ms;
      wl = (base < LEAN) ? 0 : base - LEAN;
      wr = base + LEAN;
      res.left_speed = wl[11:0];
      res.right_speed = wr[11:0];
      return 1'b1;
    end
    span = it.now_ms - pid_last_ms;
    dt = clamp_range(span, DT_FLOOR, DT_CEIL);
    pid_last_ms = it.now_ms;
    meas = it.right_dist;
    tgt = rg_target;
    dead = rg_dead;
    err = meas - tgt;
    mag = (err < 0) ? -err : err;
    // Inside the dead band: clear the integral, drive straight
    if (mag < dead) begin
      pid_integral = 0;
      pid_last_err = err;
      res.left_speed = base[11:0];
      res.right_speed = base[11:0];
      return 1'b1;
    end
    pid_integral = clamp_range(pid_integral + err * dt, -INTEG_CAP, INTEG_CAP);
    delta = err - pid_last_err;
    pid_last_err = err;
    num = longint'(rg_gp) * err * 1000 * dt + longint'(rg_gi) * pid_integral * dt
        + longint'(rg_gd) * delta * 1000000;
    den = Q_SCALE * dt;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    corr = (num < 0) ? -quo : quo;
    corr = clamp_range(corr, -half, half);
    wl = clamp_range(base + corr, WHEEL_FLOOR, base + half);
    wr = clamp_range(base - corr, WHEEL_FLOOR, base + half);
    res.left_speed = wl[11:0];
    res.right_speed = wr[11:0];
    return 1'b1;
  endfunction

  function automatic void add_row(input bit fn, input int d, input bit g, input bit [31:0] ms,
                                  input bit typed, input bit has, input int l, input int r);
    stim_row_t row;
    row.item.func = fn;
    row.item.right_dist = d[12:0];
    row.item.guard_enable = g;
    row.item.now_ms = ms;
    row.typed = typed;
    row.has_res = has;
    row.res.left_speed = l[11:0];
    row.res.right_speed = r[11:0];
    plan.push_back(row);
  endfunction

  // Build a random item: mostly samples near the target with plausible time steps
  function automatic in_item_t random_item();
    in_item_t it;
    int       d, span;
    case ($urandom_range(9))
      0: ;
      1: stamp_ms = $urandom();
      2: stamp_ms = stamp_ms + $urandom_range(5000, 501);
      default: stamp_ms = stamp_ms + $urandom_range(500, 1);
    endcase
    span = 3 * int'(rg_dead) + 40;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: d = int'(rg_target) + int'($urandom_range(2 * span)) - span;
      6, 7, 8: d = $urandom_range(DIST_TOP);
      default: begin
        case ($urandom_range(3))
          0: d = 0;
          1: d = DIST_TOP;
          2: d = rg_wall;
          default: d = int'(rg_wall) + 1;
        endcase
      end
    endcase
    if (d < 0) d = 0;
    if (d > DIST_TOP) d = DIST_TOP;
    it.func = ($urandom_range(99) < 5) ? FUNC_RESET : FUNC_STEP;
    it.right_dist = d[12:0];
    it.guard_enable = ($urandom_range(99) < 30);
    it.now_ms = stamp_ms;
    return it;
  endfunction

  // Offer one item, wait for it to be taken, then log what should come out
  task automatic send_item(input in_item_t it, input bit typed, input bit typed_has,
                           input out_item_t typed_res);
    out_item_t guess;
    bit        has;
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = predict_speeds(it, guess);
    if (typed) begin
      if (typed_has) speeds_due.push_back(typed_res);
    end else if (has) begin
      speeds_due.push_back(guess);
    end
  endtask

  // Hold input, wait for every pending result, then let the block go quiet
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (speeds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CfgDataW-1:0];
    @(posedge clk);
    case (idx)
      REG_TARGET:    rg_target = val[9:0];
      REG_DEAD_BAND: rg_dead = val[7:0];
      REG_WALL_MAX:  rg_wall = val[12:0];
      REG_GAIN_P:    rg_gp = val[11:0];
      REG_GAIN_I:    rg_gi = val[11:0];
      REG_GAIN_D:    rg_gd = val[11:0];
      REG_BASE:      rg_base = val[10:0];
      default: ;
    endcase
  endtask

  // Load the register set for one phase
  task automatic load_setting(input int ph);
    case (ph)
      1: begin
        write_reg(REG_TARGET, 1023);
        write_reg(REG_DEAD_BAND, 0);
        write_reg(REG_WALL_MAX, 6400);
        write_reg(REG_GAIN_P, 4095);
        write_reg(REG_GAIN_I, 4095);
        write_reg(REG_GAIN_D, 4095);
        write_reg(REG_BASE, 1600);
        write_reg(REG_SPARE, 8191);
      end
      2: begin
        write_reg(REG_TARGET, 0);
        write_reg(REG_DEAD_BAND, 255);
        write_reg(REG_WALL_MAX, 0);
        write_reg(REG_GAIN_P, 0);
        write_reg(REG_GAIN_I, 0);
        write_reg(REG_GAIN_D, 0);
        write_reg(REG_BASE, 0);
      end
      3: begin
        write_reg(REG_TARGET, $urandom_range(1023));
        write_reg(REG_DEAD_BAND, 8);
        write_reg(REG_WALL_MAX, 6400);
        write_reg(REG_GAIN_P, 300);
        write_reg(REG_GAIN_I, 2000);
        write_reg(REG_GAIN_D, 100);
        write_reg(REG_BASE, 100);
      end
      default: begin
        write_reg(REG_TARGET, $urandom_range(1023));
        write_reg(REG_DEAD_BAND, $urandom_range(40));
        write_reg(REG_WALL_MAX, $urandom_range(6400, 100));
        write_reg(REG_GAIN_P, $urandom_range(1023));
        write_reg(REG_GAIN_I, $urandom_range(4095));
        write_reg(REG_GAIN_D, $urandom_range(1023));
        write_reg(REG_BASE, $urandom_range(1600));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, a long hold-off on request, none while calm
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_seq) begin
        hold_done = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < 29);
    end
  end

  // Check each result against the oldest expected speed pair
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (speeds_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, left_speed %0d right_speed %0d",
                 $time, out_data.left_speed, out_data.right_speed);
      end else begin
        due_now = speeds_due.pop_front();
        if (out_data.left_speed !== due_now.left_speed) begin
          errors++;
          $display("%0t: left_speed expected %0d got %0d",
                   $time, due_now.left_speed, out_data.left_speed);
        end
        if (out_data.right_speed !== due_now.right_speed) begin
          errors++;
          $display("%0t: right_speed expected %0d got %0d",
                   $time, due_now.right_speed, out_data.right_speed);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int ph, n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rg_target = RST_TARGET;
    rg_dead = RST_DEAD_BAND;
    rg_wall = RST_WALL_MAX;
    rg_gp = RST_GAIN_P;
    rg_gi = RST_GAIN_I;
    rg_gd = RST_GAIN_D;
    rg_base = RST_BASE;
    pid_integral = 0;
    pid_last_err = 0;
    pid_last_ms = '0;

    // Directed table under reset settings: reset item, guard, dead band, clamps, time wrap
    add_row(FUNC_RESET, 0,    1'b0, 32'd0,          1'b1, 1'b0, 0,    0);
    add_row(FUNC_STEP,  6400, 1'b1, 32'd10,         1'b1, 1'b1, 768,  832);
    add_row(FUNC_STEP,  152,  1'b0, 32'd20,         1'b1, 1'b1, 800,  800);
    add_row(FUNC_STEP,  0,    1'b0, 32'd30,         1'b0, 1'b0, 0,    0);
    add_row(FUNC_STEP,  6400, 1'b0, 32'd40,         1'b1, 1'b1, 1200, 400);
    add_row(FUNC_STEP,  0,    1'b0, 32'd40,         1'b1, 1'b1, 400,  1200);
    add_row(FUNC_STEP,  129,  1'b0, 32'd50,         1'b1, 1'b1, 800,  800);
    add_row(FUNC_STEP,  176,  1'b0, 32'd60,         1'b0, 1'b0, 0,    0);
    add_row(FUNC_STEP,  200,  1'b1, 32'd70,         1'b0, 1'b0, 0,    0);
    add_row(FUNC_STEP,  201,  1'b1, 32'd80,         1'b1, 1'b1, 768,  832);
    add_row(FUNC_RESET, 6400, 1'b1, 32'hFFFF_FF00,  1'b1, 1'b0, 0,    0);
    add_row(FUNC_STEP,  300,  1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, 0,    0);
    add_row(FUNC_STEP,  100,  1'b0, 32'h0000_0010,  1'b0, 1'b0, 0,    0);
    add_row(FUNC_STEP,  152,  1'b1, 32'h8000_0000,  1'b1, 1'b1, 800,  800);
    add_row(FUNC_STEP,  4095, 1'b0, 32'h7FFF_FFFF,  1'b0, 1'b0, 0,    0);
    add_row(FUNC_STEP,  2730, 1'b0, 32'h5555_5555,  1'b0, 1'b0, 0,    0);
    add_row(FUNC_STEP,  5461, 1'b0, 32'hAAAA_AAAA,  1'b0, 1'b0, 0,    0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) send_item(plan[k].item, plan[k].typed, plan[k].has_res, plan[k].res);
    stamp_ms = 32'hAAAA_AAAA;

    // Random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle_idle();
        load_setting(ph);
      end
      calm <= (ph == 4);
      if (ph == 5) hold_seq <= hold_seq + 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 2) settle_idle();
        send_item(random_item(), 1'b0, 1'b0, '0);
      end
    end

    settle_idle();
    if (errors == 0 && speeds_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
